FILE: hdl/phmi_pkg.sv
// Shared types, codes and constants of the polynomial hit-or-miss integrator.
`default_nettype none

package phmi_pkg;

  localparam int MAX_TERMS  = 5;
  localparam int TERM_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int Q_W        = 32;
  localparam int WIDTH_W    = 33;
  localparam int Y_SPAN_W   = 24;
  localparam int W200_W     = 41;
  localparam int HIT_W      = 33;
  localparam int SAMP_W     = 32;
  localparam int EST_W      = 48;
  localparam int OUT_FLD_W  = HIT_W + SAMP_W + EST_W;
  localparam int OUT_W      = ((OUT_FLD_W + 7) / 8) * 8;

  localparam logic signed [Q_W-1:0]  Y_LOW     = -32'sd6553600;
  localparam logic [Y_SPAN_W-1:0]    Y_SPAN    = 24'd13107200;
  localparam logic [7:0]             EST_SCALE = 8'd200;
  localparam logic [TERM_W-1:0]      TERM_RST  = 3'd1;
  localparam logic [Q_W-1:0]         LEFT_RST  = 32'h0000_0000;
  localparam logic [Q_W-1:0]         RIGHT_RST = 32'h0001_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TERM_COUNT,
    REG_LEFT_LIMIT,
    REG_RIGHT_LIMIT,
    REG_COEF_0,
    REG_COEF_1,
    REG_COEF_2,
    REG_COEF_3,
    REG_COEF_4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP,
    ST_XDIV,
    ST_XSET,
    ST_MULC,
    ST_ACC,
    ST_POWUP,
    ST_HIT,
    ST_EST_GO,
    ST_EST_WAIT,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_MUL,
    DV_DIV
  } dv_phase_t;

  typedef struct packed {
    logic              capture;
    logic              map_load;
    logic              xy_set;
    logic              mul_coef;
    logic              mul_pow;
    logic              acc;
    logic              pw_upd;
    logic              hit_upd;
    logic              est_start;
    logic              out_load;
    logic              cnt_clr;
    logic [TERM_W-1:0] term_idx;
  } cmd_t;

  typedef struct packed {
    logic              last;
    logic              cnt_full;
    logic              red_done;
    logic              est_busy;
    logic [TERM_W-1:0] term_num;
  } stat_t;

endpackage

`default_nettype wire

FILE: hdl/phmi_cdiv.sv
// Iterative divider by the constant 2^N-1 using end-around folding of the remainder.
`default_nettype none

module phmi_cdiv #(
  parameter int W = 49,
  parameter int N = 16
) (
  input  wire logic         clk,
  input  wire logic         load,
  input  wire logic [W-1:0] num,
  output logic      [W-1:0] quo,
  output logic              done
);

  localparam logic [W-1:0] M = W'({N{1'b1}});

  logic [W-1:0] rem_r;
  logic [W-1:0] quo_r;
  logic [W-1:0] hi;
  logic [W-1:0] lo;

  assign hi   = rem_r >> N;
  assign lo   = rem_r & M;
  assign quo  = quo_r;
  assign done = (hi == '0) && (rem_r != M);

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= num;
      quo_r <= '0;
    end else if (hi != '0) begin
      quo_r <= quo_r + hi;
      rem_r <= hi + lo;
    end else if (rem_r == M) begin
      quo_r <= quo_r + W'(1);
      rem_r <= '0;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/phmi_divu.sv
// Bit-serial multiply followed by restoring division for the integral estimate.
`default_nettype none

module phmi_divu #(
  parameter int CB = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic [CB:0]                       mag,
  input  wire logic [phmi_pkg::W200_W-1:0]       mcand,
  input  wire logic [CB-1:0]                     divisor,
  output logic                                   busy,
  output logic [CB+phmi_pkg::W200_W:0]           quo
);

  localparam int MAG_W = CB + 1;
  localparam int DW    = MAG_W + phmi_pkg::W200_W;
  localparam int CNT_W = $clog2(DW + 1);

  phmi_pkg::dv_phase_t phase_r, phase_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  logic [DW-1:0]    acc_r;
  logic [DW-1:0]    mcand_r;
  logic [MAG_W-1:0] mplier_r;
  logic [CB-1:0]    div_r;
  logic [CB-1:0]    rem_r;
  logic [DW-1:0]    quo_r;
  logic [CB:0]      rem_sh;
  logic             qbit;

  assign busy   = (phase_r != phmi_pkg::DV_IDLE);
  assign quo    = quo_r;
  assign rem_sh = {rem_r, acc_r[DW-1]};
  assign qbit   = (rem_sh >= {1'b0, div_r});

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    case (phase_r)
      phmi_pkg::DV_IDLE: begin
        if (start) begin
          phase_nxt = phmi_pkg::DV_MUL;
          cnt_nxt   = CNT_W'(MAG_W);
        end
      end
      phmi_pkg::DV_MUL: begin
        if (cnt_r == CNT_W'(1)) begin
          phase_nxt = phmi_pkg::DV_DIV;
          cnt_nxt   = CNT_W'(DW);
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      phmi_pkg::DV_DIV: begin
        if (cnt_r == CNT_W'(1)) begin
          phase_nxt = phmi_pkg::DV_IDLE;
        end
        cnt_nxt = cnt_r - CNT_W'(1);
      end
      default: begin
        phase_nxt = phmi_pkg::DV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= phmi_pkg::DV_IDLE;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && (phase_r == phmi_pkg::DV_IDLE)) begin
      acc_r    <= '0;
      mcand_r  <= DW'(mcand);
      mplier_r <= mag;
      div_r    <= divisor;
      rem_r    <= '0;
      quo_r    <= '0;
    end else if (phase_r == phmi_pkg::DV_MUL) begin
      if (mplier_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
    end else if (phase_r == phmi_pkg::DV_DIV) begin
      rem_r <= qbit ? CB'(rem_sh - {1'b0, div_r}) : CB'(rem_sh);
      acc_r <= acc_r << 1;
      quo_r <= {quo_r[DW-2:0], qbit};
    end
  end

endmodule

`default_nettype wire

FILE: hdl/phmi_dpath.sv
// Datapath: configuration registers, sample mapping, polynomial unit, counters, result.
`default_nettype none

module phmi_dpath #(
  parameter int SB = 16,
  parameter int CB = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_valid,
  input  wire logic [phmi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [phmi_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic [((2*SB+7)/8)*8-1:0]            in_tdata,
  input  wire logic                                 in_tlast,
  input  wire phmi_pkg::cmd_t                       cmd,
  output phmi_pkg::stat_t                           stat,
  output logic [phmi_pkg::OUT_W-1:0]                out_tdata
);

  localparam int PXW = SB + phmi_pkg::WIDTH_W;
  localparam int PYW = SB + phmi_pkg::Y_SPAN_W;
  localparam int DW  = CB + 1 + phmi_pkg::W200_W;
  localparam int QW  = phmi_pkg::Q_W;
  localparam int EW  = phmi_pkg::EST_W;
  localparam logic [DW-1:0] EST_POS_MAX = DW'({(EW-1){1'b1}});
  localparam logic [DW-1:0] EST_NEG_MAX = EST_POS_MAX + DW'(1);

  function automatic logic signed [QW-1:0] qsat(input logic signed [2*QW-1:0] p);
    logic signed [2*QW-1:0] s;
    logic signed [QW-1:0]   r;
    s = p >>> 16;
    if (s > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (s < -64'sh0000_0000_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = s[QW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [QW-1:0] sadd(input logic signed [QW-1:0] a,
                                                input logic signed [QW-1:0] b);
    logic signed [QW:0]   s;
    logic signed [QW-1:0] r;
    s = {a[QW-1], a} + {b[QW-1], b};
    if (s[QW] != s[QW-1]) begin
      r = s[QW] ? -32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = s[QW-1:0];
    end
    return r;
  endfunction

  // Configuration registers.
  logic [phmi_pkg::TERM_W-1:0] term_r;
  logic signed [QW-1:0]        left_r;
  logic signed [QW-1:0]        right_r;
  logic signed [QW-1:0]        coef_r [phmi_pkg::MAX_TERMS];
  logic [phmi_pkg::CFG_IDX_W-1:0] coef_wsel;

  assign coef_wsel = cfg_index - phmi_pkg::REG_COEF_0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_r  <= phmi_pkg::TERM_RST;
      left_r  <= phmi_pkg::LEFT_RST;
      right_r <= phmi_pkg::RIGHT_RST;
      for (int k = 0; k < phmi_pkg::MAX_TERMS; k++) begin
        coef_r[k] <= '0;
      end
    end else if (cfg_valid) begin
      if (cfg_index == phmi_pkg::REG_TERM_COUNT) begin
        term_r <= cfg_data[phmi_pkg::TERM_W-1:0];
      end else if (cfg_index == phmi_pkg::REG_LEFT_LIMIT) begin
        left_r <= cfg_data;
      end else if (cfg_index == phmi_pkg::REG_RIGHT_LIMIT) begin
        right_r <= cfg_data;
      end else if (cfg_index >= phmi_pkg::REG_COEF_0) begin
        coef_r[coef_wsel] <= cfg_data;
      end
    end
  end

  logic [phmi_pkg::TERM_W-1:0] term_eff;

  always_comb begin
    if (term_r == '0) begin
      term_eff = phmi_pkg::TERM_W'(1);
    end else if (term_r > phmi_pkg::TERM_W'(phmi_pkg::MAX_TERMS)) begin
      term_eff = phmi_pkg::TERM_W'(phmi_pkg::MAX_TERMS);
    end else begin
      term_eff = term_r;
    end
  end

  // Sample capture.
  logic signed [QW:0]              diff_w;
  logic [phmi_pkg::WIDTH_W-1:0]    width_c;
  logic [SB-1:0]                   fx_r;
  logic [SB-1:0]                   fy_r;
  logic                            last_r;
  logic [phmi_pkg::WIDTH_W-1:0]    width_r;
  logic                            neg_r;

  assign diff_w  = $signed({right_r[QW-1], right_r}) - $signed({left_r[QW-1], left_r});
  assign width_c = diff_w[QW] ? phmi_pkg::WIDTH_W'(-diff_w) : phmi_pkg::WIDTH_W'(diff_w);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      fx_r    <= in_tdata[SB-1:0];
      fy_r    <= in_tdata[2*SB-1:SB];
      last_r  <= in_tlast;
      width_r <= width_c;
      neg_r   <= diff_w[QW];
    end
  end

  // Mapping of the fractions onto x and y.
  logic [PXW-1:0] prod_x;
  logic [PYW-1:0] prod_y;
  logic [PXW-1:0] qx;
  logic [PYW-1:0] qy;
  logic           done_x;
  logic           done_y;

  assign prod_x = PXW'(fx_r) * PXW'(width_r);
  assign prod_y = PYW'(fy_r) * PYW'(phmi_pkg::Y_SPAN);

  phmi_cdiv #(.W(PXW), .N(SB)) u_cdiv_x (
    .clk  (clk),
    .load (cmd.map_load),
    .num  (prod_x),
    .quo  (qx),
    .done (done_x)
  );

  phmi_cdiv #(.W(PYW), .N(SB)) u_cdiv_y (
    .clk  (clk),
    .load (cmd.map_load),
    .num  (prod_y),
    .quo  (qy),
    .done (done_y)
  );

  logic signed [QW+1:0] left_ext;
  logic signed [QW+1:0] off_ext;
  logic signed [QW+1:0] x_w;

  assign left_ext = {{2{left_r[QW-1]}}, left_r};
  assign off_ext  = {1'b0, qx[phmi_pkg::WIDTH_W-1:0]};
  assign x_w      = neg_r ? (left_ext - off_ext) : (left_ext + off_ext);

  // Polynomial evaluation with one shared multiplier.
  logic signed [QW-1:0]   x_r;
  logic signed [QW-1:0]   y_r;
  logic signed [QW-1:0]   pw_r;
  logic signed [QW-1:0]   sum_r;
  logic signed [2*QW-1:0] prod_r;
  logic signed [QW-1:0]   mul_a;
  logic signed [QW-1:0]   mul_b;
  logic signed [QW-1:0]   q_prod;

  assign mul_a  = cmd.mul_coef ? coef_r[cmd.term_idx] : pw_r;
  assign mul_b  = cmd.mul_coef ? pw_r : x_r;
  assign q_prod = qsat(prod_r);

  always_ff @(posedge clk) begin
    if (cmd.xy_set) begin
      x_r   <= x_w[QW-1:0];
      pw_r  <= x_w[QW-1:0];
      sum_r <= coef_r[0];
      y_r   <= phmi_pkg::Y_LOW + $signed(QW'(qy[phmi_pkg::Y_SPAN_W-1:0]));
    end else begin
      if (cmd.pw_upd) begin
        pw_r <= q_prod;
      end
      if (cmd.acc) begin
        sum_r <= sadd(sum_r, q_prod);
      end
    end
    if (cmd.mul_coef || cmd.mul_pow) begin
      prod_r <= mul_a * mul_b;
    end
  end

  // Hit and sample counters.
  logic [CB:0]   hit_r;
  logic [CB-1:0] samp_r;
  logic          hit_up;
  logic          hit_dn;

  assign hit_up = (sum_r >= 0) && (y_r >= 0) && (y_r <= sum_r);
  assign hit_dn = (sum_r < 0) && (y_r >= sum_r) && (y_r <= 0);

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.cnt_clr) begin
      hit_r  <= '0;
      samp_r <= '0;
    end else if (cmd.hit_upd) begin
      if (hit_up) begin
        hit_r <= hit_r + 1'b1;
      end else if (hit_dn) begin
        hit_r <= hit_r - 1'b1;
      end
      samp_r <= samp_r + 1'b1;
    end
  end

  // Estimate unit.
  logic [CB:0]                   mag;
  logic [phmi_pkg::W200_W-1:0]   w200;
  logic [DW-1:0]                 quo;
  logic                          est_busy;

  assign mag  = hit_r[CB] ? (~hit_r + 1'b1) : hit_r;
  assign w200 = phmi_pkg::W200_W'(width_r) * phmi_pkg::W200_W'(phmi_pkg::EST_SCALE);

  phmi_divu #(.CB(CB)) u_divu (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.est_start),
    .mag     (mag),
    .mcand   (w200),
    .divisor (samp_r),
    .busy    (est_busy),
    .quo     (quo)
  );

  logic [EW-1:0]              est_c;
  logic [DW-1:0]              mag_sat;
  logic [phmi_pkg::HIT_W-1:0]  hit_c;
  logic [phmi_pkg::SAMP_W-1:0] samp_c;

  always_comb begin
    if (hit_r[CB]) begin
      mag_sat = (quo > EST_NEG_MAX) ? EST_NEG_MAX : quo;
      est_c   = EW'(DW'(0) - mag_sat);
    end else begin
      mag_sat = (quo > EST_POS_MAX) ? EST_POS_MAX : quo;
      est_c   = EW'(mag_sat);
    end
    if (samp_r == '0) begin
      est_c = '0;
    end
  end

  assign hit_c  = phmi_pkg::HIT_W'($signed(hit_r));
  assign samp_c = phmi_pkg::SAMP_W'(samp_r);

  logic [phmi_pkg::OUT_W-1:0] out_tdata_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_tdata_r <= phmi_pkg::OUT_W'({est_c, samp_c, hit_c});
    end
  end

  assign out_tdata = out_tdata_r;

  assign stat.last     = last_r;
  assign stat.cnt_full = &samp_r;
  assign stat.red_done = done_x && done_y;
  assign stat.est_busy = est_busy;
  assign stat.term_num = term_eff;

endmodule

`default_nettype wire

FILE: hdl/phmi_ctrl.sv
// Controller state machine sequencing mapping, polynomial terms, counting and results.
`default_nettype none

module phmi_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  input  wire phmi_pkg::stat_t stat,
  output phmi_pkg::cmd_t       cmd
);

  phmi_pkg::state_t            state_r, state_nxt;
  logic [phmi_pkg::TERM_W-1:0] i_r, i_nxt;
  logic                        out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt    = state_r;
    i_nxt        = i_r;
    cmd          = '0;
    cmd.term_idx = i_r;
    in_tready    = 1'b0;
    case (state_r)
      phmi_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = phmi_pkg::ST_MAP;
        end
      end
      phmi_pkg::ST_MAP: begin
        if (stat.cnt_full) begin
          state_nxt = stat.last ? phmi_pkg::ST_EST_GO : phmi_pkg::ST_IDLE;
        end else begin
          cmd.map_load = 1'b1;
          state_nxt    = phmi_pkg::ST_XDIV;
        end
      end
      phmi_pkg::ST_XDIV: begin
        if (stat.red_done) begin
          state_nxt = phmi_pkg::ST_XSET;
        end
      end
      phmi_pkg::ST_XSET: begin
        cmd.xy_set = 1'b1;
        i_nxt      = phmi_pkg::TERM_W'(1);
        if (stat.term_num > phmi_pkg::TERM_W'(1)) begin
          state_nxt = phmi_pkg::ST_MULC;
        end else begin
          state_nxt = phmi_pkg::ST_HIT;
        end
      end
      phmi_pkg::ST_MULC: begin
        cmd.mul_coef = 1'b1;
        state_nxt    = phmi_pkg::ST_ACC;
      end
      phmi_pkg::ST_ACC: begin
        cmd.acc = 1'b1;
        if ((i_r + phmi_pkg::TERM_W'(1)) < stat.term_num) begin
          cmd.mul_pow = 1'b1;
          i_nxt       = i_r + phmi_pkg::TERM_W'(1);
          state_nxt   = phmi_pkg::ST_POWUP;
        end else begin
          state_nxt = phmi_pkg::ST_HIT;
        end
      end
      phmi_pkg::ST_POWUP: begin
        cmd.pw_upd = 1'b1;
        state_nxt  = phmi_pkg::ST_MULC;
      end
      phmi_pkg::ST_HIT: begin
        cmd.hit_upd = 1'b1;
        state_nxt   = stat.last ? phmi_pkg::ST_EST_GO : phmi_pkg::ST_IDLE;
      end
      phmi_pkg::ST_EST_GO: begin
        cmd.est_start = 1'b1;
        state_nxt     = phmi_pkg::ST_EST_WAIT;
      end
      phmi_pkg::ST_EST_WAIT: begin
        if (!stat.est_busy) begin
          state_nxt = phmi_pkg::ST_OUT;
        end
      end
      phmi_pkg::ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          cmd.cnt_clr  = 1'b1;
          state_nxt    = phmi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = phmi_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= phmi_pkg::ST_IDLE;
      i_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_mul_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.mul_coef && cmd.mul_pow))
    else $error("coefficient and power multiplies issued together");

  a_est_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.est_start |=> stat.est_busy)
    else $error("estimate unit did not start");

  a_term_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == phmi_pkg::ST_MULC) |-> ((i_r != '0) && (i_r < stat.term_num)))
    else $error("term index out of range");

  a_term_num: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.term_num != '0) && (stat.term_num <= phmi_pkg::TERM_W'(phmi_pkg::MAX_TERMS)))
    else $error("effective term count out of range");

endmodule

`default_nettype wire

FILE: hdl/poly_hit_or_miss_integrator_unit.sv
// Top level of the Monte Carlo hit-or-miss polynomial integrator.
// The input stream carries one sample point per transaction: two uniform fractions
// in in_tdata and the end-of-integral mark in in_tlast. Each sample is mapped to x
// in the configured limits and y in [-100, 100], the polynomial is evaluated with
// one shared 32x32 multiplier, and the signed hit counter is updated.
// A new sample is accepted only after the previous one has been fully processed;
// the time per sample is set by the constant-divide folding steps and by the
// multiply, accumulate and power steps of the shared multiplier for each term.
// A sample with in_tlast set also runs the estimate unit, a bit-serial multiply
// and restoring divide, and then emits one result transaction with the hit total,
// the sample count and the estimate; both counters are cleared at that point.
// The result sits in an output register, so a new sample is accepted while the
// receiver stalls; a second result waits until the first has been taken.
// Reset clears the counters and loads the register defaults: one term, limits
// 0 and 1.0, all coefficients zero. The configuration channel is always ready
// and must only be written while no sample is in flight.
`default_nettype none

module poly_hit_or_miss_integrator_unit #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // in_tdata: frac_x, frac_y
  input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    in_tdata,
  input  wire logic                                  in_tlast,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // out_tdata: hit_total, samples_taken, estimate
  output logic [phmi_pkg::OUT_W-1:0]                 out_tdata,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [phmi_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [phmi_pkg::CFG_DATA_W-1:0]       cfg_data
);

  phmi_pkg::cmd_t  cmd;
  phmi_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  phmi_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  phmi_dpath #(.SB(SAMPLE_BITS), .CB(COUNT_BITS)) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cmd       (cmd),
    .stat      (stat),
    .out_tdata (out_tdata)
  );

endmodule

`default_nettype wire
